### sv/xetl_pkg.sv
// ----------------------------------------------------------------------------
// xetl_pkg
// Shared types, codes and constants of the cross-reference entry table loader.
// ----------------------------------------------------------------------------
`default_nettype none
package xetl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int OFFSET_BITS         = 40;
  localparam int MAX_FIELD_BYTES     = 8;
  localparam int ENTRY_BUF           = 24;
  localparam int TEXT_LEN            = 20;
  localparam int OFF_DIGITS          = 10;
  localparam int GEN_FIRST           = 11;
  localparam int GEN_LAST            = 15;
  localparam int TYPE_CHAR_POS       = 17;
  localparam int DEC_W               = 34;
  localparam int BC_W                = $clog2(ENTRY_BUF + 1);

  localparam logic [63:0] OFF_MASK   = 64'((65'd1 << OFFSET_BITS) - 65'd1);
  localparam logic [7:0]  CHAR_F     = 8'h66;
  localparam logic [7:0]  CHAR_N     = 8'h6e;
  localparam logic [7:0]  CHAR_0     = 8'h30;
  localparam logic [7:0]  CHAR_9     = 8'h39;

  // entry types
  localparam logic [1:0] TY_FREE = 2'd0;
  localparam logic [1:0] TY_USED = 2'd1;
  localparam logic [1:0] TY_COMP = 2'd2;
  localparam logic [1:0] TY_UNKN = 2'd3;

  // result kinds
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_LOOK  = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_LOOK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_BEYOND  = 3'd4,
    ST_OVF     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_TW   = 2'd1,
    CFG_OW   = 2'd2,
    CFG_GW   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXTRACT,
    S_RD_ENT,
    S_WR_ENT,
    S_LOOK_RSP
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [23:0] first_object;
    logic [23:0] section_count;
    logic [31:0] query_gen;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [2:0]             status;
    logic [23:0]            object_number;
    logic                   entry_written;
    logic                   found;
    logic [1:0]             entry_type;
    logic [OFFSET_BITS-1:0] entry_offset;
    logic [31:0]            entry_gen;
    logic [12:0]            table_size;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic sub_start;
    logic take_byte;
    logic beyond;
    logic ext_step;
    logic parse;
    logic commit;
    logic look_rd;
    logic look_rsp;
    logic rd_cur;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic none_left;
    logic will_done;
    logic text_mode;
    logic ext_last;
  } stat_t;

  function automatic logic [3:0] clamp_w(input logic [3:0] w);
    return (w > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : w;
  endfunction

endpackage
`default_nettype wire

### sv/xref_entry_table_loader.sv
// ----------------------------------------------------------------------------
// xref_entry_table_loader
// Fills an object entry table from text or binary cross-reference entries.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Op start
// subsection loads the first object and count. Op entry byte takes one
// byte a cycle while busy is low; the byte that completes an entry starts
// the update: binary entries first pass through byte-serial field
// extraction over type+offset+generation width bytes (at least one), then
// the slot is read and then written. Text entries go straight to the slot
// read. The result is registered at the slot write and then appears on
// out_item. A byte after the subsection count is answered in the next
// cycle with status beyond count. A lookup reads the slot when it is taken,
// holds busy in its response state and answers from the result register.
// Results appear on out_item for one cycle with out_valid; the receiver
// cannot stall. Throughput is set by the read-then-write update of each
// slot and the byte-serial extraction. After reset busy stays high while the
// slot type store is swept clear; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module xref_entry_table_loader #(
  parameter int TABLE_DEPTH = xetl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [3:0]          cfg_wdata,
  input  wire logic                start,
  output logic                     busy,
  input  wire xetl_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output xetl_pkg::out_item_t      out_item
);

  xetl_pkg::cmd_t  cmd;
  xetl_pkg::stat_t st;

  // sequencer
  xetl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  xetl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### sv/xetl_ctrl.sv
// ----------------------------------------------------------------------------
// xetl_ctrl
// Sequencer: clearing pass, byte intake, field extraction, slot update, lookup.
// ----------------------------------------------------------------------------
`default_nettype none
module xetl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      op,
  input  wire xetl_pkg::stat_t st,
  output xetl_pkg::cmd_t       cmd,
  output logic                 busy
);

  xetl_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xetl_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      xetl_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = xetl_pkg::S_IDLE;
      end
      xetl_pkg::S_IDLE: begin
        if (start) begin
          unique case (xetl_pkg::op_t'(op))
            xetl_pkg::OP_START: cmd.sub_start = 1'b1;
            xetl_pkg::OP_BYTE: begin
              if (st.none_left) begin
                cmd.beyond = 1'b1;
              end else begin
                cmd.take_byte = 1'b1;
                if (st.will_done) begin
                  state_nxt = st.text_mode ? xetl_pkg::S_RD_ENT : xetl_pkg::S_EXTRACT;
                end
              end
            end
            xetl_pkg::OP_LOOK: begin
              cmd.look_rd = 1'b1;
              state_nxt   = xetl_pkg::S_LOOK_RSP;
            end
            xetl_pkg::OP_NOP: ;
            default: ;
          endcase
        end
      end
      xetl_pkg::S_EXTRACT: begin
        cmd.ext_step = 1'b1;
        cmd.rd_cur   = 1'b1;
        if (st.ext_last) state_nxt = xetl_pkg::S_RD_ENT;
      end
      xetl_pkg::S_RD_ENT: begin
        cmd.parse  = 1'b1;
        cmd.rd_cur = 1'b1;
        state_nxt  = xetl_pkg::S_WR_ENT;
      end
      xetl_pkg::S_WR_ENT: begin
        cmd.commit = 1'b1;
        cmd.rd_cur = 1'b1;
        state_nxt  = xetl_pkg::S_IDLE;
      end
      xetl_pkg::S_LOOK_RSP: begin
        cmd.look_rsp = 1'b1;
        state_nxt    = xetl_pkg::S_IDLE;
      end
      default: state_nxt = xetl_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != xetl_pkg::S_IDLE);

  // extraction always ends in a slot read
  a_ext_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xetl_pkg::S_EXTRACT |=>
      state_r == xetl_pkg::S_EXTRACT || state_r == xetl_pkg::S_RD_ENT)
    else $error("extraction left to a wrong state");

  // slot read is followed by the update
  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xetl_pkg::S_RD_ENT |=> state_r == xetl_pkg::S_WR_ENT)
    else $error("slot update skipped");

  // an accepted lookup moves to its response state in the next cycle
  a_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xetl_pkg::S_IDLE && start && op == xetl_pkg::OP_LOOK) |=>
      state_r == xetl_pkg::S_LOOK_RSP)
    else $error("lookup not answered");

endmodule
`default_nettype wire

### sv/xetl_dp.sv
// ----------------------------------------------------------------------------
// xetl_dp
// Datapath: configuration, entry buffer, field parsing, slot memories, results.
// ----------------------------------------------------------------------------
`default_nettype none
module xetl_dp #(
  parameter int TABLE_DEPTH = xetl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_idx,
  input  wire logic [3:0]           cfg_wdata,
  input  wire xetl_pkg::in_item_t   in_item,
  input  wire xetl_pkg::cmd_t       cmd,
  output xetl_pkg::stat_t           st,
  output logic                      out_valid,
  output xetl_pkg::out_item_t       out_item
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int US_W  = $clog2(TABLE_DEPTH + 1);
  localparam int OB    = xetl_pkg::OFFSET_BITS;
  localparam int BC_W  = xetl_pkg::BC_W;

  // configuration registers
  logic       mode_r;
  logic [3:0] tw_r, ow_r, gw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      tw_r   <= 4'd1;
      ow_r   <= 4'd2;
      gw_r   <= 4'd1;
    end else if (cfg_we) begin
      unique case (xetl_pkg::cfg_idx_t'(cfg_idx))
        xetl_pkg::CFG_MODE: mode_r <= cfg_wdata[0];
        xetl_pkg::CFG_TW:   tw_r   <= cfg_wdata;
        xetl_pkg::CFG_OW:   ow_r   <= cfg_wdata;
        xetl_pkg::CFG_GW:   gw_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [3:0]      tw, ow, gw;
  logic [BC_W-1:0] len;
  logic [BC_W-1:0] bin_len;

  assign tw      = xetl_pkg::clamp_w(tw_r);
  assign ow      = xetl_pkg::clamp_w(ow_r);
  assign gw      = xetl_pkg::clamp_w(gw_r);
  assign bin_len = BC_W'(tw) + BC_W'(ow) + BC_W'(gw);
  assign len     = mode_r ? BC_W'(xetl_pkg::TEXT_LEN) :
                   ((bin_len == '0) ? BC_W'(1) : bin_len);

  // subsection and byte counters
  logic [BC_W-1:0] bc_r;
  logic [23:0]     cur_r, left_r;
  logic [US_W-1:0] used_r;
  logic            done_now;

  assign done_now = ({1'b0, bc_r} + 1'b1) >= {1'b0, len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r   <= '0;
      cur_r  <= '0;
      left_r <= '0;
    end else if (cmd.sub_start) begin
      bc_r   <= '0;
      cur_r  <= in_item.first_object;
      left_r <= in_item.section_count;
    end else if (cmd.take_byte) begin
      bc_r <= done_now ? '0 : bc_r + 1'b1;
    end else if (cmd.commit) begin
      cur_r  <= cur_r + 24'd1;
      left_r <= left_r - 24'd1;
    end
  end

  // entry byte buffer
  logic [7:0] ebuf_r [xetl_pkg::ENTRY_BUF];

  always_ff @(posedge clk) begin
    if (cmd.take_byte && (bc_r < BC_W'(xetl_pkg::ENTRY_BUF))) begin
      ebuf_r[bc_r] <= in_item.data_byte;
    end
  end

  // running decimal fields for text entries
  logic [xetl_pkg::DEC_W-1:0] doff_r, dgen_r, dbase, dmul;
  logic                       off_ok_r, gen_ok_r, is_dig, gen_pos;
  logic [7:0]                 tchar_r;
  logic [xetl_pkg::DEC_W-1:0] digit;

  assign is_dig  = (in_item.data_byte >= xetl_pkg::CHAR_0) &&
                   (in_item.data_byte <= xetl_pkg::CHAR_9);
  assign digit   = xetl_pkg::DEC_W'(in_item.data_byte - xetl_pkg::CHAR_0);
  assign gen_pos = (bc_r >= BC_W'(xetl_pkg::GEN_FIRST)) &&
                   (bc_r <= BC_W'(xetl_pkg::GEN_LAST));

  always_comb begin
    if (bc_r < BC_W'(xetl_pkg::OFF_DIGITS)) begin
      dbase = (bc_r == '0) ? '0 : doff_r;
    end else begin
      dbase = (bc_r == BC_W'(xetl_pkg::GEN_FIRST)) ? '0 : dgen_r;
    end
    dmul = (dbase << 3) + (dbase << 1) + digit;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (bc_r < BC_W'(xetl_pkg::OFF_DIGITS)) begin
        doff_r   <= dmul;
        off_ok_r <= ((bc_r == '0) ? 1'b1 : off_ok_r) & is_dig;
      end
      if (gen_pos) begin
        dgen_r   <= dmul;
        gen_ok_r <= ((bc_r == BC_W'(xetl_pkg::GEN_FIRST)) ? 1'b1 : gen_ok_r) & is_dig;
      end
      if (bc_r == BC_W'(xetl_pkg::TYPE_CHAR_POS)) tchar_r <= in_item.data_byte;
    end
  end

  // binary field extraction, one byte a cycle
  logic [BC_W-1:0] xi_r;
  logic [63:0]     tacc_r, oacc_r, gacc_r;
  logic [7:0]      xb;

  assign xb = ebuf_r[xi_r];

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      xi_r   <= '0;
      tacc_r <= '0;
      oacc_r <= '0;
      gacc_r <= '0;
    end else if (cmd.ext_step) begin
      xi_r <= xi_r + 1'b1;
      if (xi_r < BC_W'(tw)) begin
        tacc_r <= {tacc_r[55:0], xb};
      end else if (xi_r < BC_W'(tw) + BC_W'(ow)) begin
        oacc_r <= {oacc_r[55:0], xb};
      end else begin
        gacc_r <= {gacc_r[55:0], xb};
      end
    end
  end

  // parse the collected entry
  logic [2:0]    p_status, s1;
  logic [1:0]    p_type;
  logic [63:0]   p_off;
  logic [31:0]   p_gen;
  logic          p_gen_ovf;

  always_comb begin
    p_type    = xetl_pkg::TY_FREE;
    p_off     = '0;
    p_gen     = '0;
    p_gen_ovf = 1'b0;
    s1        = xetl_pkg::ST_OK;
    if (mode_r) begin
      p_off = off_ok_r ? 64'(doff_r) : xetl_pkg::OFF_MASK;
      if (off_ok_r && (64'(doff_r) > xetl_pkg::OFF_MASK)) s1 = xetl_pkg::ST_OVF;
      p_gen = gen_ok_r ? 32'(dgen_r) : 32'hFFFF_FFFF;
      if (tchar_r == xetl_pkg::CHAR_F) begin
        p_type = xetl_pkg::TY_FREE;
      end else if (tchar_r == xetl_pkg::CHAR_N) begin
        p_type = xetl_pkg::TY_USED;
      end else begin
        s1 = xetl_pkg::ST_BADCHAR;
      end
      p_status = s1;
    end else begin
      if (tw != 4'd0) begin
        p_type = (tacc_r > 64'd2) ? xetl_pkg::TY_UNKN : tacc_r[1:0];
      end else begin
        p_type = xetl_pkg::TY_USED;
      end
      if (ow == 4'd0) begin
        s1 = xetl_pkg::ST_MISSING;
      end else begin
        p_off = oacc_r;
        if (oacc_r > xetl_pkg::OFF_MASK) s1 = xetl_pkg::ST_OVF;
      end
      if (gw != 4'd0) begin
        p_gen     = gacc_r[31:0];
        p_gen_ovf = (gacc_r[63:32] != '0);
        p_status  = (p_gen_ovf && s1 == xetl_pkg::ST_OK) ? xetl_pkg::ST_OVF : s1;
      end else begin
        p_status = (p_type != xetl_pkg::TY_USED) ? xetl_pkg::ST_MISSING : s1;
      end
    end
    if (p_status == xetl_pkg::ST_OK && cur_r >= 24'(TABLE_DEPTH)) begin
      p_status = xetl_pkg::ST_FULL;
    end
  end

  logic [2:0]    pr_status_r;
  logic [1:0]    pr_type_r;
  logic [OB-1:0] pr_off_r;
  logic [31:0]   pr_gen_r;

  always_ff @(posedge clk) begin
    if (cmd.parse) begin
      pr_status_r <= p_status;
      pr_type_r   <= p_type;
      pr_off_r    <= p_off[OB-1:0];
      pr_gen_r    <= p_gen;
    end
  end

  // slot memories; the type store is swept clear after reset
  logic [2:0]       stype_mem [TABLE_DEPTH];
  logic [OB-1:0]    soff_mem  [TABLE_DEPTH];
  logic [31:0]      sgen_mem  [TABLE_DEPTH];
  logic [IDX_W-1:0] clr_r, rd_addr, cur_idx;
  logic [2:0]       st_q;
  logic [OB-1:0]    so_q;
  logic [31:0]      sg_q;
  logic             do_wr, t_we;
  logic [IDX_W-1:0] t_wa;
  logic [2:0]       t_wd;

  assign cur_idx = cur_r[IDX_W-1:0];
  assign rd_addr = cmd.rd_cur ? cur_idx : in_item.first_object[IDX_W-1:0];
  assign do_wr   = cmd.commit && (pr_status_r == xetl_pkg::ST_OK) &&
                   (!st_q[2] || ((sg_q < pr_gen_r) && (st_q[1:0] != xetl_pkg::TY_COMP)));
  assign t_we    = cmd.clr_step || do_wr;
  assign t_wa    = cmd.clr_step ? clr_r : cur_idx;
  assign t_wd    = cmd.clr_step ? 3'b000 : {1'b1, pr_type_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) stype_mem[t_wa] <= t_wd;
    st_q <= stype_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      soff_mem[cur_idx] <= pr_off_r;
      sgen_mem[cur_idx] <= pr_gen_r;
    end
    so_q <= soff_mem[rd_addr];
    sg_q <= sgen_mem[rd_addr];
  end

  // table size
  logic [US_W-1:0] used_nxt;
  logic [24:0]     cur_p1;

  assign cur_p1   = {1'b0, cur_r} + 25'd1;
  assign used_nxt = (do_wr && (cur_p1 > 25'(used_r))) ? US_W'(cur_p1) : used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // lookup query
  logic [23:0] q_obj_r;
  logic [31:0] q_gen_r;
  logic        q_hit;

  always_ff @(posedge clk) begin
    if (cmd.look_rd) begin
      q_obj_r <= in_item.first_object;
      q_gen_r <= in_item.query_gen;
    end
  end

  assign q_hit = (32'(q_obj_r) < 32'(used_r)) && (q_obj_r < 24'(TABLE_DEPTH)) && st_q[2];

  // result register
  logic      ov_r;
  logic      keep;

  assign keep = (pr_status_r == xetl_pkg::ST_OK) || (pr_status_r == xetl_pkg::ST_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cmd.beyond || cmd.commit || cmd.look_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beyond) begin
      out_item.result_kind   <= xetl_pkg::KIND_ENTRY;
      out_item.status        <= xetl_pkg::ST_BEYOND;
      out_item.object_number <= cur_r;
      out_item.entry_written <= 1'b0;
      out_item.found         <= 1'b0;
      out_item.entry_type    <= xetl_pkg::TY_FREE;
      out_item.entry_offset  <= '0;
      out_item.entry_gen     <= '0;
      out_item.table_size    <= 13'(used_r);
    end else if (cmd.commit) begin
      out_item.result_kind   <= xetl_pkg::KIND_ENTRY;
      out_item.status        <= pr_status_r;
      out_item.object_number <= cur_r;
      out_item.entry_written <= do_wr;
      out_item.found         <= 1'b0;
      out_item.entry_type    <= keep ? pr_type_r : xetl_pkg::TY_FREE;
      out_item.entry_offset  <= keep ? pr_off_r : '0;
      out_item.entry_gen     <= keep ? pr_gen_r : '0;
      out_item.table_size    <= 13'(used_nxt);
    end else if (cmd.look_rsp) begin
      out_item.result_kind   <= xetl_pkg::KIND_LOOK;
      out_item.status        <= xetl_pkg::ST_OK;
      out_item.object_number <= q_obj_r;
      out_item.entry_written <= 1'b0;
      out_item.found         <= q_hit && (st_q[1:0] != xetl_pkg::TY_FREE) && (sg_q == q_gen_r);
      out_item.entry_type    <= q_hit ? st_q[1:0] : xetl_pkg::TY_FREE;
      out_item.entry_offset  <= q_hit ? so_q : '0;
      out_item.entry_gen     <= q_hit ? sg_q : '0;
      out_item.table_size    <= 13'(used_r);
    end
  end

  assign out_valid = ov_r;

  // status to the controller
  assign st.clr_last  = (clr_r == IDX_W'(TABLE_DEPTH - 1));
  assign st.none_left = (left_r == '0);
  assign st.will_done = done_now;
  assign st.text_mode = mode_r;
  assign st.ext_last  = ((xi_r + 1'b1) == len);

endmodule
`default_nettype wire
